// ===== rtl/core/mbs_pkg.sv =====
// shared types, codes and sizes of the multipart boundary scanner
package mbs_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int PTR_W       = $clog2(MAX_PATTERN);
	localparam int CNT_W       = PTR_W + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] DASH_BYTE = 8'h2D;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_DATA   = 2'd0;
	localparam cmd_t CMD_END    = 2'd1;
	localparam cmd_t CMD_LOAD   = 2'd2;
	localparam cmd_t CMD_RESUME = 2'd3;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_BODY     = 2'd0;
	localparam kind_t KIND_BOUNDARY = 2'd1;
	localparam kind_t KIND_HEADER   = 2'd2;
	localparam kind_t KIND_END      = 2'd3;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CMP   = 3'd1;
	localparam logic [2:0] ST_REL   = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data;
		logic [5:0] index;
	} op_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       fin;
	} res_t;

	typedef struct packed {
		logic [2:0]       state;
		logic [CNT_W-1:0] count;
		logic             mode;
		logic [1:0]       dash;
		logic             pend_valid;
	} bk_status_t;

endpackage

// ===== rtl/core/mbs_front.sv =====
// input side: accepts stream transfers, decodes them into operations and queues them
module mbs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,
	input  logic [1:0]        s_tuser,
	output logic              q_valid,
	output mbs_pkg::op_t      q_op,
	input  logic              q_pop
);

	mbs_pkg::op_t                  queue_q [mbs_pkg::QUEUE_DEPTH];
	logic [mbs_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [mbs_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [mbs_pkg::QPTR_W:0]      fill_q;
	mbs_pkg::op_t                  op_in;
	logic                          push;
	logic                          pop;

	always_comb begin
		op_in.cmd   = s_tuser;
		op_in.data  = s_tdata[7:0];
		op_in.index = s_tdata[13:8];
		// a data byte never carries a store index
		if (s_tuser != mbs_pkg::CMD_LOAD) begin
			op_in.index = '0;
		end
	end

	assign s_tready = (fill_q != (mbs_pkg::QPTR_W+1)'(mbs_pkg::QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (fill_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_op     = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mbs_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mbs_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (mbs_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (mbs_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== rtl/core/mbs_back.sv =====
// scan engine: held window and pattern memories, serial compare, result register
module mbs_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [6:0]              cfg_wdata,
	input  logic                    q_valid,
	input  mbs_pkg::op_t            q_op,
	output logic                    q_pop,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [7:0]              m_tdata,
	output logic [2:0]              m_tuser,
	output logic                    m_tlast,
	output mbs_pkg::bk_status_t     status
);

	localparam int PW = mbs_pkg::PTR_W;
	localparam int CW = mbs_pkg::CNT_W;

	logic [7:0] win_mem [mbs_pkg::MAX_PATTERN];
	logic [7:0] pat_mem [mbs_pkg::MAX_PATTERN];

	logic [2:0]    state_q, state_n;
	logic [PW-1:0] head_q, head_n;
	logic [CW-1:0] count_q, count_n;
	logic [PW-1:0] idx_q, idx_n;
	logic          mode_q, mode_n;
	logic [1:0]    dash_q, dash_n;
	logic          verified_q, verified_n;
	logic [6:0]    len_q;
	logic          pend_valid_q, pend_valid_n;
	mbs_pkg::res_t pend_q, pend_n;
	logic          out_valid_q;
	mbs_pkg::res_t out_q;
	logic          out_last_q;

	logic [7:0]    win_rdata_q;
	logic [7:0]    pat_rdata_q;
	logic [PW-1:0] win_raddr;
	logic          win_we;
	logic [PW-1:0] win_waddr;
	logic          pat_we;

	logic [CW-1:0] len_eff;
	logic          out_free;
	logic          put_ok;
	logic          mismatch;
	logic          out_load;
	mbs_pkg::res_t out_res;
	logic          out_last;
	logic [1:0]    dash_hdr;

	always_comb begin
		if (len_q == '0) begin
			len_eff = CW'(1);
		end else if (len_q > 7'(mbs_pkg::MAX_PATTERN)) begin
			len_eff = CW'(mbs_pkg::MAX_PATTERN);
		end else begin
			len_eff = CW'(len_q);
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign put_ok   = !pend_valid_q || out_free;
	assign mismatch = (count_q > len_eff) || (win_rdata_q != pat_rdata_q);

	always_comb begin
		dash_hdr = dash_q;
		if (dash_q < 2'd2) begin
			dash_hdr = (q_op.data == mbs_pkg::DASH_BYTE) ? dash_q + 2'd1 : 2'd3;
		end
	end

	always_comb begin
		state_n      = state_q;
		head_n       = head_q;
		count_n      = count_q;
		idx_n        = idx_q;
		mode_n       = mode_q;
		dash_n       = dash_q;
		verified_n   = verified_q;
		pend_valid_n = pend_valid_q;
		pend_n       = pend_q;
		q_pop        = 1'b0;
		win_we       = 1'b0;
		win_waddr    = head_q + count_q[PW-1:0];
		pat_we       = 1'b0;
		out_load     = 1'b0;
		out_res      = pend_q;
		out_last     = 1'b0;

		unique case (state_q)
			mbs_pkg::ST_IDLE: begin
				if (q_valid) begin
					unique case (q_op.cmd)
						mbs_pkg::CMD_DATA: begin
							if (!mode_q) begin
								q_pop   = 1'b1;
								win_we  = 1'b1;
								count_n = count_q + CW'(1);
								// a verified window only needs the new byte checked
								idx_n   = verified_q ? count_q[PW-1:0] : '0;
								state_n = mbs_pkg::ST_CMP;
							end else if (out_free) begin
								q_pop        = 1'b1;
								dash_n       = dash_hdr;
								out_load     = 1'b1;
								out_res.kind = mbs_pkg::KIND_HEADER;
								out_res.data = q_op.data;
								out_res.fin  = (dash_hdr == 2'd2);
								out_last     = 1'b1;
							end
						end
						mbs_pkg::CMD_END: begin
							if (!mode_q && count_q != '0) begin
								q_pop   = 1'b1;
								idx_n   = '0;
								state_n = mbs_pkg::ST_FLUSH;
							end else if (out_free) begin
								q_pop        = 1'b1;
								out_load     = 1'b1;
								out_res.kind = mbs_pkg::KIND_END;
								out_res.data = '0;
								out_res.fin  = 1'b0;
								out_last     = 1'b1;
							end
						end
						mbs_pkg::CMD_LOAD: begin
							q_pop      = 1'b1;
							pat_we     = (7'(q_op.index) < 7'(mbs_pkg::MAX_PATTERN));
							verified_n = 1'b0;
						end
						mbs_pkg::CMD_RESUME: begin
							q_pop  = 1'b1;
							mode_n = 1'b0;
							dash_n = '0;
						end
						default: ;
					endcase
				end
			end

			mbs_pkg::ST_CMP: begin
				if (mismatch) begin
					if (idx_q == '0) begin
						// read data is the oldest held byte: release it
						if (put_ok) begin
							if (pend_valid_q) begin
								out_load = 1'b1;
							end
							pend_valid_n = 1'b1;
							pend_n.kind  = mbs_pkg::KIND_BODY;
							pend_n.data  = win_rdata_q;
							pend_n.fin   = 1'b0;
							head_n       = head_q + PW'(1);
							count_n      = count_q - CW'(1);
							state_n      = (count_q == CW'(1)) ? mbs_pkg::ST_FIN : mbs_pkg::ST_CMP;
						end
					end else begin
						idx_n   = '0;
						state_n = mbs_pkg::ST_REL;
					end
				end else if (({1'b0, idx_q} + CW'(1)) < count_q) begin
					idx_n = idx_q + PW'(1);
				end else if (count_q == len_eff) begin
					if (put_ok) begin
						if (pend_valid_q) begin
							out_load = 1'b1;
						end
						pend_valid_n = 1'b1;
						pend_n.kind  = mbs_pkg::KIND_BOUNDARY;
						pend_n.data  = '0;
						pend_n.fin   = 1'b0;
						count_n      = '0;
						idx_n        = '0;
						mode_n       = 1'b1;
						dash_n       = '0;
						verified_n   = 1'b1;
						state_n      = mbs_pkg::ST_FIN;
					end
				end else begin
					verified_n = 1'b1;
					state_n    = pend_valid_q ? mbs_pkg::ST_FIN : mbs_pkg::ST_IDLE;
				end
			end

			mbs_pkg::ST_REL: begin
				if (put_ok) begin
					if (pend_valid_q) begin
						out_load = 1'b1;
					end
					pend_valid_n = 1'b1;
					pend_n.kind  = mbs_pkg::KIND_BODY;
					pend_n.data  = win_rdata_q;
					pend_n.fin   = 1'b0;
					head_n       = head_q + PW'(1);
					count_n      = count_q - CW'(1);
					state_n      = (count_q == CW'(1)) ? mbs_pkg::ST_FIN : mbs_pkg::ST_CMP;
				end
			end

			mbs_pkg::ST_FIN: begin
				if (!pend_valid_q) begin
					state_n = mbs_pkg::ST_IDLE;
				end else if (out_free) begin
					out_load     = 1'b1;
					out_last     = 1'b1;
					pend_valid_n = 1'b0;
					state_n      = mbs_pkg::ST_IDLE;
				end
			end

			mbs_pkg::ST_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					if (count_q == '0) begin
						out_res.kind = mbs_pkg::KIND_END;
						out_res.data = '0;
						out_res.fin  = 1'b0;
						out_last     = 1'b1;
						state_n      = mbs_pkg::ST_IDLE;
					end else begin
						out_res.kind = mbs_pkg::KIND_BODY;
						out_res.data = win_rdata_q;
						out_res.fin  = 1'b0;
						head_n       = head_q + PW'(1);
						count_n      = count_q - CW'(1);
					end
				end
			end

			default: begin
				state_n = mbs_pkg::ST_IDLE;
			end
		endcase
	end

	// reads follow the next head and index so data lines up with the registered state
	assign win_raddr = head_n + idx_n;

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_waddr] <= q_op.data;
		end
		if (win_we && win_waddr == win_raddr) begin
			win_rdata_q <= q_op.data;
		end else begin
			win_rdata_q <= win_mem[win_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[q_op.index[PW-1:0]] <= q_op.data;
		end
		pat_rdata_q <= pat_mem[idx_n];
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_n;
		if (out_load) begin
			out_q      <= out_res;
			out_last_q <= out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mbs_pkg::ST_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			mode_q       <= 1'b0;
			dash_q       <= '0;
			verified_q   <= 1'b0;
			len_q        <= 7'd4;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_n;
			head_q       <= head_n;
			count_q      <= count_n;
			idx_q        <= idx_n;
			mode_q       <= mode_n;
			dash_q       <= dash_n;
			pend_valid_q <= pend_valid_n;
			if (cfg_we) begin
				len_q      <= cfg_wdata;
				verified_q <= 1'b0;
			end else begin
				verified_q <= verified_n;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.data;
	assign m_tuser  = {out_q.fin, out_q.kind};
	assign m_tlast  = out_last_q;

	assign status.state      = state_q;
	assign status.count      = count_q;
	assign status.mode       = mode_q;
	assign status.dash       = dash_q;
	assign status.pend_valid = pend_valid_q;

endmodule

// ===== rtl/core/multipart_boundary_scanner_top.sv =====
// top level of the multipart boundary scanner: front queue, scan engine, checks
// Pattern loads, resumes, header bytes and end of stream outside body mode are
// handled directly in the idle state of the engine. A body byte is popped from the queue and
// then compared while the held bytes stay a prefix of the pattern; a boundary closes the run
// in a final state. After a mismatch held bytes are released one at a time, through a release
// state when the break was past the first held byte, and the remaining held bytes are compared
// one at a time, since the window and pattern memories have one read port each. End of stream
// in body mode releases each held byte and then an end marker. A four-entry queue in front
// lets the input side keep accepting while the engine works or the output stalls.
module multipart_boundary_scanner_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,     // pattern_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,       // data_byte [7:0], pattern_index [13:8], zero [15:14]
	input  logic [1:0]  s_tuser,       // cmd [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,       // out_byte [7:0]
	output logic [2:0]  m_tuser,       // kind [1:0], final_part [2]
	output logic        m_tlast
);

	logic                 q_valid;
	mbs_pkg::op_t         q_op;
	logic                 q_pop;
	mbs_pkg::bk_status_t  st;

	mbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_pop    (q_pop)
	);

	mbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.status    (st)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st.count <= mbs_pkg::CNT_W'(mbs_pkg::MAX_PATTERN))
		else $error("held window count beyond pattern store size");

	a_header_empty: assert property (@(posedge clk) disable iff (!arst_n)
		st.mode |-> (st.count == '0))
		else $error("bytes held while in header mode");

	a_dash_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(st.dash != 2'd0) |-> st.mode)
		else $error("dash count set outside header mode");

	a_pend_state: assert property (@(posedge clk) disable iff (!arst_n)
		st.pend_valid |-> (st.state == mbs_pkg::ST_CMP || st.state == mbs_pkg::ST_REL ||
			st.state == mbs_pkg::ST_FIN))
		else $error("pending result left over outside a body scan");

endmodule
